### sv/slcp_pkg.sv
// Package for the serial LED command parser: beat structs, queue entry,
// message codes, back-end states and the fixed command and message text.
// No dependencies.
package slcp_pkg;

   localparam logic [7:0] CR_BYTE = 8'h0D;
   localparam logic [7:0] LF_BYTE = 8'h0A;

   // Commands, in match order
   localparam int CMD_COUNT    = 6;
   localparam int CMD_MAX_LEN  = 11;
   localparam int CMD_IDX_W    = 4;
   localparam logic [2:0] CMD_G_ON     = 3'd0;
   localparam logic [2:0] CMD_G_OFF    = 3'd1;
   localparam logic [2:0] CMD_G_STATUS = 3'd2;
   localparam logic [2:0] CMD_R_ON     = 3'd3;
   localparam logic [2:0] CMD_R_OFF    = 3'd4;
   localparam logic [2:0] CMD_R_STATUS = 3'd5;

   localparam int MSG_MAX_LEN = 19;
   localparam int MSG_IDX_W   = 5;

   typedef enum logic [2:0] {
      MSG_NONE,
      MSG_UNDEF,
      MSG_G_ON,
      MSG_G_OFF,
      MSG_R_ON,
      MSG_R_OFF
   } slcp_msg_type;

   typedef enum logic {
      BK_IDLE,
      BK_MSG
   } slcp_bstate_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       mode;
   } slcp_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       red_led;
      logic       green_led;
      logic       last_of_run;
   } slcp_rsp_type;

   typedef struct packed {
      logic [7:0]   echo;
      slcp_msg_type msg;
      logic         red;
      logic         green;
   } slcp_entry_type;

   // Command text, left justified and space padded to CMD_MAX_LEN
   function automatic logic [8*CMD_MAX_LEN-1:0] cmd_text(input logic [2:0] k);
      unique case (k)
         CMD_G_ON:     return "gLed On    ";
         CMD_G_OFF:    return "gLed Off   ";
         CMD_G_STATUS: return "gLed Status";
         CMD_R_ON:     return "rLed On    ";
         CMD_R_OFF:    return "rLed Off   ";
         CMD_R_STATUS: return "rLed Status";
         default:      return '0;
      endcase
   endfunction

   function automatic logic [CMD_IDX_W-1:0] cmd_len(input logic [2:0] k);
      unique case (k)
         CMD_G_ON, CMD_R_ON:         return CMD_IDX_W'(7);
         CMD_G_OFF, CMD_R_OFF:       return CMD_IDX_W'(8);
         CMD_G_STATUS, CMD_R_STATUS: return CMD_IDX_W'(11);
         default:                    return '0;
      endcase
   endfunction

   // Caller keeps idx below CMD_MAX_LEN
   function automatic logic [7:0] cmd_char(input logic [2:0] k,
                                           input logic [CMD_IDX_W-1:0] idx);
      logic [8*CMD_MAX_LEN-1:0] t;
      t = cmd_text(k);
      return t[8*(CMD_MAX_LEN-1-int'(idx)) +: 8];
   endfunction

   // Message text, left justified and zero padded to MSG_MAX_LEN
   function automatic logic [8*MSG_MAX_LEN-1:0] msg_text(input slcp_msg_type m);
      unique case (m)
         MSG_UNDEF: return {"Undefined command", CR_BYTE, LF_BYTE};
         MSG_G_ON:  return {"Gled status: on", CR_BYTE, LF_BYTE, 16'h0};
         MSG_G_OFF: return {"Gled status: off", CR_BYTE, LF_BYTE, 8'h0};
         MSG_R_ON:  return {"Rled status: on", CR_BYTE, LF_BYTE, 16'h0};
         MSG_R_OFF: return {"Rled status: off", CR_BYTE, LF_BYTE, 8'h0};
         default:   return '0;
      endcase
   endfunction

   function automatic logic [MSG_IDX_W-1:0] msg_len(input slcp_msg_type m);
      unique case (m)
         MSG_UNDEF:           return MSG_IDX_W'(19);
         MSG_G_ON, MSG_R_ON:  return MSG_IDX_W'(17);
         MSG_G_OFF, MSG_R_OFF: return MSG_IDX_W'(18);
         default:             return '0;
      endcase
   endfunction

   // Caller keeps idx below MSG_MAX_LEN
   function automatic logic [7:0] msg_char(input slcp_msg_type m,
                                           input logic [MSG_IDX_W-1:0] idx);
      logic [8*MSG_MAX_LEN-1:0] t;
      t = msg_text(m);
      return t[8*(MSG_MAX_LEN-1-int'(idx)) +: 8];
   endfunction

endpackage

### sv/slcp_front.sv
// Front end: accepts request beats, tracks the phone line and matches it
// against the commands as bytes arrive, owns the LED state. Uses slcp_pkg.
module slcp_front
   import slcp_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  slcp_req_type   req_data,
   output logic           req_stall,
   input  logic           q_full,
   output logic           q_push,
   output slcp_entry_type q_data
);

   localparam int LW = $clog2(LINE_DEPTH + 1);

   logic [LW-1:0]        len_ff, len_in;
   logic                 ovf_ff, ovf_in;
   logic [CMD_COUNT-1:0] mask_ff, mask_in;
   logic                 red_ff, red_in;
   logic                 green_ff, green_in;
   logic [CMD_COUNT-1:0] hit;
   logic                 accept;
   logic                 green_hit, red_hit;
   logic [CMD_IDX_W-1:0] pos;
   slcp_msg_type         msg;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign q_push    = accept;
   assign pos       = CMD_IDX_W'(len_ff);

   always_comb begin
      for (int k = 0; k < CMD_COUNT; k++) begin
         hit[k] = mask_ff[k] && !ovf_ff && (len_ff == LW'(cmd_len(3'(k))));
      end
   end

   assign green_hit = hit[CMD_G_ON] || hit[CMD_G_OFF] || hit[CMD_G_STATUS];
   assign red_hit   = hit[CMD_R_ON] || hit[CMD_R_OFF] || hit[CMD_R_STATUS];

   always_comb begin
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      mask_in  = mask_ff;
      red_in   = red_ff;
      green_in = green_ff;
      msg      = MSG_NONE;
      if (accept && req_data.mode) begin
         if (req_data.rx_byte == CR_BYTE) begin
            if (hit[CMD_G_ON])  green_in = 1'b1;
            if (hit[CMD_G_OFF]) green_in = 1'b0;
            if (hit[CMD_R_ON])  red_in   = 1'b1;
            if (hit[CMD_R_OFF]) red_in   = 1'b0;
            if (green_hit) begin
               msg = green_in ? MSG_G_ON : MSG_G_OFF;
            end else if (red_hit) begin
               msg = red_in ? MSG_R_ON : MSG_R_OFF;
            end else begin
               msg = MSG_UNDEF;
            end
            len_in  = '0;
            ovf_in  = 1'b0;
            mask_in = '1;
         end else if (len_ff < LW'(LINE_DEPTH)) begin
            len_in = len_ff + LW'(1);
            // drop candidates that disagree at this position
            for (int k = 0; k < CMD_COUNT; k++) begin
               mask_in[k] = mask_ff[k] && (len_ff < LW'(CMD_MAX_LEN)) &&
                            (pos < cmd_len(3'(k))) &&
                            (req_data.rx_byte == cmd_char(3'(k), pos));
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_comb begin
      q_data.echo  = req_data.rx_byte;
      q_data.msg   = msg;
      q_data.red   = red_in;
      q_data.green = green_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         mask_ff  <= '1;
         red_ff   <= 1'b0;
         green_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         mask_ff  <= mask_in;
         red_ff   <= red_in;
         green_ff <= green_in;
      end
   end

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LW'(LINE_DEPTH)))
      else $error("overflow flag set with line store not full");

endmodule

### sv/slcp_queue.sv
// Two-entry queue between front and back end, holds classified bytes.
// Uses slcp_pkg.
module slcp_queue
   import slcp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  slcp_entry_type push_data,
   output logic           full,
   input  logic           pop,
   output slcp_entry_type pop_data,
   output logic           empty
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   slcp_entry_type ent_ff [DEPTH];
   logic [PW-1:0]  wr_ff, rd_ff;
   logic [CW-1:0]  cnt_ff;
   logic           do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = ent_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) ent_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         if (do_pop)  rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + CW'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - CW'(1);
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

### sv/slcp_back.sv
// Back end: sequencer that plays the echo beat and then the message text
// from the queue into the response output register. Uses slcp_pkg.
module slcp_back
   import slcp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  slcp_entry_type q_data,
   output logic           q_pop,
   output logic           rsp_valid,
   output slcp_rsp_type   rsp_data,
   input  logic           rsp_stall
);

   slcp_bstate_type      state_ff, state_in;
   slcp_entry_type       cur_ff, cur_in;
   logic [MSG_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   slcp_rsp_type         rsp_ff, rsp_in;
   logic                 adv, emit, at_last;

   // output register is free or being drained this cycle
   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign at_last = (idx_ff == MSG_IDX_W'(msg_len(cur_ff.msg) - MSG_IDX_W'(1)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (adv && !q_empty && q_data.msg != MSG_NONE) state_in = BK_MSG;
         end
         BK_MSG: begin
            if (adv && at_last) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      emit   = 1'b0;
      q_pop  = 1'b0;
      cur_in = cur_ff;
      idx_in = idx_ff;
      rsp_in = rsp_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (adv && !q_empty) begin
               emit               = 1'b1;
               q_pop              = 1'b1;
               cur_in             = q_data;
               idx_in             = '0;
               rsp_in.out_byte    = q_data.echo;
               rsp_in.red_led     = q_data.red;
               rsp_in.green_led   = q_data.green;
               rsp_in.last_of_run = (q_data.msg == MSG_NONE);
            end
         end
         BK_MSG: begin
            if (adv) begin
               emit               = 1'b1;
               idx_in             = idx_ff + MSG_IDX_W'(1);
               rsp_in.out_byte    = msg_char(cur_ff.msg, idx_ff);
               rsp_in.red_led     = cur_ff.red;
               rsp_in.green_led   = cur_ff.green;
               rsp_in.last_of_run = at_last;
            end
         end
         default: ;
      endcase
      rsp_valid_in = adv ? emit : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_of_run) |-> (state_ff == BK_IDLE))
      else $error("last beat shown while message still pending");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MSG) |-> (idx_ff < msg_len(cur_ff.msg)))
      else $error("message index past end of text");

endmodule

### sv/serial_led_command_parser_top.sv
// Top level of the serial LED command parser: front end, queue, back end.
// Uses slcp_pkg, slcp_front, slcp_queue and slcp_back.
//
// Usage:
//   req_ channel: one beat per received byte, req_data.rx_byte with
//   req_data.mode (0 PC terminal, 1 phone link). rsp_ channel: the echo of
//   every byte, followed on a phone carriage return by the status message or
//   "Undefined command" text. Every rsp_ beat carries the LED levels after
//   its request was handled; last_of_run marks the final beat of a request.
//   red_led/green_led travel in the response beats only.
// Flow and throughput:
//   A request's echo beat passes through the queue and then the response
//   output register before it shows on rsp_, and is held there while
//   rsp_stall is high. The back-end sequencer puts out one beat per cycle
//   while rsp_stall is low: one beat per plain byte, and the echo plus 17
//   to 19 text bytes for a line end with a message. The front end takes a
//   new byte each cycle while the two-entry queue has room.
// Reset:
//   Synchronous, active high. Clears the line, the overflow flag, both LEDs,
//   the queue and the output valid flag. No clearing pass is needed.
// Stall:
//   rsp_stall holds the output beat and the sequencer; the queue then fills
//   and req_stall rises until the back end drains an entry.
module serial_led_command_parser_top
   import slcp_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  slcp_req_type req_data,
   output logic         req_stall,
   output logic         rsp_valid,
   output slcp_rsp_type rsp_data,
   input  logic         rsp_stall
);

   // classified byte handed from front to back
   logic           q_push, q_full, q_pop, q_empty;
   slcp_entry_type q_in, q_out;

   // accept, track the line, decide the message, advance LED state
   slcp_front #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   // decouple the two sides so each can stall on its own
   slcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // play echo then message text, one beat per cycle unless rsp_stall holds it
   slcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
